FILE: hw/rtl/owpm_pkg.sv
`default_nettype none
package owpm_pkg;

    // default duty width
    localparam int DUTY_BITS_DEF = 16;
    localparam int WHEELS = 3;

    // |v| * power fits in 23 bits, peak * 100 in 22 bits
    localparam int MAG_W = 23;
    localparam int DEN_W = 22;

    // heading bias is a multiple of 360 that makes every heading positive
    localparam int HEAD_BIAS = 33120;
    // ceil(2^25 / 360), exact for all biased headings
    localparam int RECIP360 = 93207;
    localparam int RECIP_SHIFT = 25;
    // 327.68 * 2^16, for round(|c| * 32768 / 100)
    localparam longint CORR_K = 64'd21474836;
    localparam int PCT_DEN = 100;

    // one job word handed from the front to the back
    typedef struct packed {
        logic [WHEELS-1:0][MAG_W-1:0] mult;
        logic [DEN_W-1:0]             den;
        logic [WHEELS-1:0]            neg;
        logic [WHEELS-1:0]            zero;
    } owpm_job_t;

    localparam logic [15:0] SINE_TAB [91] = '{
            0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
         5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    // full-wave q15 sine from the quarter table, angle in 0..359
    function automatic logic signed [16:0] sine_q15(input logic [8:0] ang);
        logic [8:0]  idx;
        logic        neg;
        logic [15:0] t;
        begin
            neg = 1'b0;
            if (ang <= 9'd90)
            begin
                idx = ang;
            end
            else if (ang <= 9'd180)
            begin
                idx = 9'd180 - ang;
            end
            else if (ang <= 9'd270)
            begin
                idx = ang - 9'd180;
                neg = 1'b1;
            end
            else
            begin
                idx = 9'd360 - ang;
                neg = 1'b1;
            end
            t = SINE_TAB[idx[6:0]];
            sine_q15 = neg ? -$signed({1'b0, t}) : $signed({1'b0, t});
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/owpm_front.sv
`default_nettype none
module owpm_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [15:0]     heading_degrees,
    input  wire logic [6:0]             drive_power,
    input  wire logic signed [7:0]      turn_correction,
    output logic                        job_valid,
    input  wire logic                   job_ready,
    output owpm_pkg::owpm_job_t         job
);

    logic v1_reg, v2_reg, v3_reg;
    logic en;

    // stage 1 registers
    logic [16:0] x1_reg;
    logic [7:0]  q1_reg;
    logic [15:0] cmag1_reg;
    logic [7:0]  cabs1_reg;
    logic        cneg1_reg;
    logic [6:0]  pow1_reg;

    // stage 2 registers
    logic signed [16:0] v2_val_reg [owpm_pkg::WHEELS];
    logic [7:0]         cabs2_reg;
    logic               cneg2_reg;
    logic [6:0]         pow2_reg;

    owpm_pkg::owpm_job_t job_reg;

    // whole pipe moves unless the last word is blocked
    assign en        = !v3_reg || job_ready;
    assign in_ready  = en;
    assign job_valid = v3_reg;
    assign job       = job_reg;

    // stage 1: bias heading, reciprocal multiply by 1/360, correction in q15
    logic [16:0] x_c;
    logic [33:0] xm_c;
    logic [7:0]  cabs_c;
    logic [32:0] cm_c;
    always_comb
    begin
        x_c    = 17'($signed({heading_degrees[15], heading_degrees}) +
                     17'(owpm_pkg::HEAD_BIAS));
        xm_c   = 34'(x_c) * 34'(owpm_pkg::RECIP360);
        cabs_c = turn_correction[7] ? 8'(-turn_correction) : 8'(turn_correction);
        cm_c   = 33'(cabs_c) * 33'(owpm_pkg::CORR_K) + 33'd32768;
    end

    // stage 2: angle per wheel, sine lookup, add correction and clamp
    logic [8:0]         h_c;
    logic [8:0]         ang_c [owpm_pkg::WHEELS];
    logic signed [17:0] sum_c [owpm_pkg::WHEELS];
    logic signed [16:0] vcl_c [owpm_pkg::WHEELS];
    logic signed [17:0] corr_c;
    logic [8:0]         off_c [owpm_pkg::WHEELS];
    always_comb
    begin
        off_c[0] = 9'd60;
        off_c[1] = 9'd180;
        off_c[2] = 9'd300;
        h_c    = 9'(x1_reg - 17'(q1_reg) * 17'd360);
        corr_c = cneg1_reg ? -$signed({2'b00, cmag1_reg}) : $signed({2'b00, cmag1_reg});
        for (int i = 0; i < owpm_pkg::WHEELS; i++)
        begin
            ang_c[i] = (h_c >= off_c[i]) ? 9'(h_c - off_c[i]) :
                                           9'(h_c + 9'd360 - off_c[i]);
            sum_c[i] = 18'(owpm_pkg::sine_q15(ang_c[i])) + corr_c;
            if (sum_c[i] > 18'sd32768)
            begin
                vcl_c[i] = 17'sd32768;
            end
            else if (sum_c[i] < -18'sd32768)
            begin
                vcl_c[i] = -17'sd32768;
            end
            else
            begin
                vcl_c[i] = 17'(sum_c[i]);
            end
        end
    end

    // stage 3: magnitudes, peak, numerator factor and divisor
    logic [15:0]                mag_c [owpm_pkg::WHEELS];
    logic [15:0]                peak_c;
    owpm_pkg::owpm_job_t        job_c;
    always_comb
    begin
        peak_c = '0;
        job_c  = '0;
        for (int i = 0; i < owpm_pkg::WHEELS; i++)
        begin
            mag_c[i] = v2_val_reg[i][16] ? 16'(-v2_val_reg[i]) : 16'(v2_val_reg[i]);
            if (mag_c[i] > peak_c)
            begin
                peak_c = mag_c[i];
            end
        end
        for (int i = 0; i < owpm_pkg::WHEELS; i++)
        begin
            if (pow2_reg == 7'd0)
            begin
                job_c.mult[i] = owpm_pkg::MAG_W'(cabs2_reg);
                job_c.neg[i]  = cneg2_reg;
                job_c.zero[i] = (cabs2_reg == 8'd0);
            end
            else
            begin
                job_c.mult[i] = owpm_pkg::MAG_W'(mag_c[i]) * owpm_pkg::MAG_W'(pow2_reg);
                job_c.neg[i]  = v2_val_reg[i][16];
                job_c.zero[i] = (v2_val_reg[i] == 17'sd0);
            end
        end
        if (pow2_reg == 7'd0)
        begin
            job_c.den = owpm_pkg::DEN_W'(owpm_pkg::PCT_DEN);
        end
        else
        begin
            job_c.den = owpm_pkg::DEN_W'(peak_c) * owpm_pkg::DEN_W'(owpm_pkg::PCT_DEN);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= x_c;
            q1_reg    <= xm_c[owpm_pkg::RECIP_SHIFT+7:owpm_pkg::RECIP_SHIFT];
            cmag1_reg <= cm_c[31:16];
            cabs1_reg <= cabs_c;
            cneg1_reg <= turn_correction[7];
            pow1_reg  <= drive_power;
            for (int i = 0; i < owpm_pkg::WHEELS; i++)
            begin
                v2_val_reg[i] <= vcl_c[i];
            end
            cabs2_reg <= cabs1_reg;
            cneg2_reg <= cneg1_reg;
            pow2_reg  <= pow1_reg;
            job_reg   <= job_c;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/owpm_queue.sv
`default_nettype none
module owpm_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push_valid,
    output logic                        push_ready,
    input  wire owpm_pkg::owpm_job_t    push_word,
    output logic                        pop_valid,
    input  wire logic                   pop_ready,
    output owpm_pkg::owpm_job_t         pop_word
);

    owpm_pkg::owpm_job_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_word   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/owpm_back.sv
`default_nettype none
module owpm_back #(
    parameter int DUTY_BITS = owpm_pkg::DUTY_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   job_valid,
    output logic                        job_ready,
    input  wire owpm_pkg::owpm_job_t    job,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [DUTY_BITS-1:0]        right_forward_duty,
    output logic [DUTY_BITS-1:0]        right_reverse_duty,
    output logic [DUTY_BITS-1:0]        rear_forward_duty,
    output logic [DUTY_BITS-1:0]        rear_reverse_duty,
    output logic [DUTY_BITS-1:0]        left_forward_duty,
    output logic [DUTY_BITS-1:0]        left_reverse_duty
);

    localparam int W     = owpm_pkg::WHEELS;
    localparam int NUM_W = owpm_pkg::MAG_W + DUTY_BITS + 1;
    localparam int QW    = DUTY_BITS + 1;
    localparam int CNT_W = $clog2(QW + 1);
    localparam logic [DUTY_BITS-1:0] FULL = {DUTY_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic [owpm_pkg::DEN_W:0]     rem_reg  [W];
    logic [QW-1:0]                low_reg  [W];
    logic [QW-1:0]                quo_reg  [W];
    logic [owpm_pkg::DEN_W-1:0]   den_reg;
    logic [W-1:0]                 neg_reg, zero_reg;
    logic                         out_valid_reg;
    logic [DUTY_BITS-1:0]         fwd_reg [W];
    logic [DUTY_BITS-1:0]         rev_reg [W];

    logic load, deliver;

    // the result leaves when the output word is free
    assign deliver   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign job_ready = (state_reg == ST_IDLE) || deliver;
    assign load      = job_valid && job_ready;

    // numerator with rounding term, split into start remainder and low bits
    logic [NUM_W-1:0] num_c [W];
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            num_c[i] = (NUM_W'(job.mult[i]) << DUTY_BITS) - NUM_W'(job.mult[i]) +
                       NUM_W'(job.den >> 1);
        end
    end

    // one restoring step per wheel
    logic [owpm_pkg::DEN_W:0] trial_c [W];
    logic [W-1:0]             fit_c;
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            trial_c[i] = {rem_reg[i][owpm_pkg::DEN_W-1:0], low_reg[i][QW-1]};
            fit_c[i]   = trial_c[i] >= {1'b0, den_reg};
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (deliver)
                begin
                    state_next = load ? ST_DIV : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cnt_reg  <= CNT_W'(QW);
            den_reg  <= job.den;
            neg_reg  <= job.neg;
            zero_reg <= job.zero;
            for (int i = 0; i < W; i++)
            begin
                rem_reg[i] <= (owpm_pkg::DEN_W+1)'(num_c[i] >> QW);
                low_reg[i] <= num_c[i][QW-1:0];
                quo_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_DIV)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            for (int i = 0; i < W; i++)
            begin
                rem_reg[i] <= fit_c[i] ? trial_c[i] - {1'b0, den_reg} : trial_c[i];
                low_reg[i] <= {low_reg[i][QW-2:0], 1'b0};
                quo_reg[i] <= {quo_reg[i][QW-2:0], fit_c[i]};
            end
        end
    end

    // saturate and steer to forward, reverse or brake
    logic [DUTY_BITS-1:0] duty_c [W];
    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            for (int i = 0; i < W; i++)
            begin
                if (zero_reg[i])
                begin
                    fwd_reg[i] <= FULL;
                    rev_reg[i] <= FULL;
                end
                else if (neg_reg[i])
                begin
                    fwd_reg[i] <= '0;
                    rev_reg[i] <= duty_c[i];
                end
                else
                begin
                    fwd_reg[i] <= duty_c[i];
                    rev_reg[i] <= '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            duty_c[i] = quo_reg[i][DUTY_BITS] ? FULL : quo_reg[i][DUTY_BITS-1:0];
        end
    end

    assign out_valid          = out_valid_reg;
    assign right_forward_duty = fwd_reg[0];
    assign right_reverse_duty = rev_reg[0];
    assign rear_forward_duty  = fwd_reg[1];
    assign rear_reverse_duty  = rev_reg[1];
    assign left_forward_duty  = fwd_reg[2];
    assign left_reverse_duty  = rev_reg[2];

    // the wheel 0 remainder stays below the divisor while dividing
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg[0] < {1'b0, den_reg}))
        else $error("divider remainder out of range");

    // the divisor is never zero while dividing
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (den_reg != '0))
        else $error("zero divisor");

    // a new word appears only after the sequencer finished a division
    a_deliver_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        deliver |-> $past(state_reg == ST_DIV || state_reg == ST_DONE))
        else $error("result delivered without division");

endmodule
`default_nettype wire

FILE: hw/rtl/omni_wheel_pwm_mixer_unit.sv
`default_nettype none
// channel   signals                                         direction
// input     in_valid / in_ready, heading_degrees,           in
//           drive_power, turn_correction
// output    out_valid / out_ready, six wheel duties         out
//
// a command passes three front stages into a two-word queue, then the back
// divides all three wheels in parallel, one quotient bit per cycle
// each command holds the divider until its result is delivered
// the front keeps accepting while the queue has room; a held result keeps
// the finished division waiting, and the next division starts only once
// that word has moved into the output register
// reset clears all valid bits and the sequencer; no clearing pass
module omni_wheel_pwm_mixer_unit #(
    parameter int DUTY_BITS = owpm_pkg::DUTY_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [15:0]     heading_degrees,
    input  wire logic [6:0]             drive_power,
    input  wire logic signed [7:0]      turn_correction,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [DUTY_BITS-1:0]        right_forward_duty,
    output logic [DUTY_BITS-1:0]        right_reverse_duty,
    output logic [DUTY_BITS-1:0]        rear_forward_duty,
    output logic [DUTY_BITS-1:0]        rear_reverse_duty,
    output logic [DUTY_BITS-1:0]        left_forward_duty,
    output logic [DUTY_BITS-1:0]        left_reverse_duty
);

    logic                f_valid, f_ready, b_valid, b_ready;
    owpm_pkg::owpm_job_t f_word, b_word;

    // front: angle, sine, correction, peak
    owpm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .heading_degrees (heading_degrees),
        .drive_power     (drive_power),
        .turn_correction (turn_correction),
        .job_valid       (f_valid),
        .job_ready       (f_ready),
        .job             (f_word)
    );

    // short queue between front and back
    owpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_word  (f_word),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_word   (b_word)
    );

    // back: division, saturation and direction steering
    owpm_back #(
        .DUTY_BITS (DUTY_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .job_valid          (b_valid),
        .job_ready          (b_ready),
        .job                (b_word),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .right_forward_duty (right_forward_duty),
        .right_reverse_duty (right_reverse_duty),
        .rear_forward_duty  (rear_forward_duty),
        .rear_reverse_duty  (rear_reverse_duty),
        .left_forward_duty  (left_forward_duty),
        .left_reverse_duty  (left_reverse_duty)
    );

endmodule
`default_nettype wire
